/* sv/stjs_pkg.sv */
// shared types and codes for the sorted table jump search block
// item, result and controller/datapath interface structs
// no dependencies
package stjs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int BLOCK_W     = 11;
  localparam int VALUE_W     = 32;
  localparam int INDEX_W     = 10;
  localparam int COUNT_W     = 12;
  localparam logic [BLOCK_W-1:0] BLOCK_RESET = 11'd32;

  // operation codes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_ORDER = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [1:0]                op;
    logic signed [VALUE_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic [INDEX_W-1:0] index;
    logic [COUNT_W-1:0] compare_count;
  } result_t;

  typedef struct packed {
    logic accept;
    logic jump;
    logic scan;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic jump_hit;
    logic jump_miss;
    logic scan_hit;
    logic scan_end;
  } dp_stat_t;

endpackage

/* sv/sorted_table_jump_search_core.sv */
// top level of the sorted table jump search block
// joins the controller and the datapath, depends on stjs_pkg,
// stjs_ctrl and stjs_datapath
//
//   channel   direction  handshake                  payload
//   item      in         item_valid/item_stall      stjs_pkg::item_t
//   result    out        result_valid/result_stall  stjs_pkg::result_t
//   cfg       in         cfg_valid/cfg_ready        jump distance, 11 bits
//
// clear, append, the unused op and a search of an empty table go straight to done,
// other searches through jump and scan, or from jump past the last block to done;
// result loaded in done once the output is free; one table read per cycle issued one
// ahead of its compare; jumps grow with entries / jump distance, scan at most one block
// synchronous reset empties the table and sets the jump distance to 32
// a held result blocks only the handoff; the next item is taken and then waits
module sorted_table_jump_search_core #(
  parameter int TABLE_DEPTH = stjs_pkg::TABLE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  stjs_pkg::item_t              item,
  output logic                         result_valid,
  input  logic                         result_stall,
  output stjs_pkg::result_t            result,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [stjs_pkg::BLOCK_W-1:0] cfg_data
);

  stjs_pkg::dp_cmd_t  cmd;
  stjs_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  stjs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_op      (item.op),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  stjs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .cfg_we   (cfg_valid),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .result   (result)
  );

  // one transaction at a time: busy right after an accept
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("item accepted while previous one in flight");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == stjs_pkg::ST_EMPTY |->
      !result.found && result.compare_count == '0)
    else $error("empty table search reported compares");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.found |->
      result.status == stjs_pkg::ST_OK && result.compare_count != '0)
    else $error("hit without compares or with bad status");

endmodule

/* sv/stjs_ctrl.sv */
// controller state machine for the jump search block
// sequences accept, jump phase, scan phase and result handoff
// depends on stjs_pkg
module stjs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic [1:0]         item_op,
  output logic               item_stall,
  output logic               result_valid,
  input  logic               result_stall,
  input  stjs_pkg::dp_stat_t stat,
  output stjs_pkg::dp_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_JUMP = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign item_stall = (state != S_IDLE);
  assign out_free   = !result_valid || !result_stall;

  always_comb begin
    cmd          = '0;
    cmd.accept   = (state == S_IDLE) && item_valid;
    cmd.jump     = (state == S_JUMP);
    cmd.scan     = (state == S_SCAN);
    cmd.load_out = (state == S_DONE) && out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          if (item_op == stjs_pkg::OP_SEARCH && !stat.count_zero) begin
            state_next = S_JUMP;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_JUMP: begin
        priority if (stat.jump_hit) begin
          state_next = S_SCAN;
        end else if (stat.jump_miss) begin
          state_next = S_DONE;
        end else begin
          state_next = S_JUMP;
        end
      end
      S_SCAN: begin
        if (stat.scan_hit || stat.scan_end) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

/* sv/stjs_datapath.sv */
// datapath for the jump search block: table memory, entry count,
// block size register, search pointers, comparators and result register
// depends on stjs_pkg
module stjs_datapath #(
  parameter int TABLE_DEPTH = stjs_pkg::TABLE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  stjs_pkg::item_t                 item,
  input  logic                            cfg_we,
  input  logic [stjs_pkg::BLOCK_W-1:0]    cfg_data,
  input  stjs_pkg::dp_cmd_t               cmd,
  output stjs_pkg::dp_stat_t              stat,
  output stjs_pkg::result_t               result
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int StepW = ((CntW > stjs_pkg::BLOCK_W) ? CntW : stjs_pkg::BLOCK_W) + 2;
  localparam int VW    = stjs_pkg::VALUE_W;
  localparam int IW    = stjs_pkg::INDEX_W;
  localparam int CW    = stjs_pkg::COUNT_W;

  logic signed [VW-1:0] mem [TABLE_DEPTH];
  logic signed [VW-1:0] rd_data;
  logic signed [VW-1:0] last_word;
  logic signed [VW-1:0] target;
  logic [CntW-1:0]      count;
  logic [stjs_pkg::BLOCK_W-1:0] jump_dist;

  logic [StepW-1:0] step_issue;
  logic [StepW-1:0] scan_issue;
  logic [StepW-1:0] scan_stop;
  logic [StepW-1:0] cmp_pos;
  logic             rd_vld;

  logic [1:0]       res_status;
  logic             res_found;
  logic [IW-1:0]    res_idx;
  logic [CW-1:0]    res_cmp;

  logic [stjs_pkg::BLOCK_W-1:0] bs_eff;
  logic [StepW-1:0] bs_ext;
  logic [StepW-1:0] n_ext;
  logic [StepW-1:0] jump_lim;
  logic [StepW-1:0] jump_addr;
  logic [AW-1:0]    rd_addr;
  logic             is_full;
  logic             is_order;
  logic             do_write;
  logic             ge_target;
  logic             eq_target;
  logic [CW-1:0]    cmp_inc;

  assign bs_eff    = (jump_dist == '0) ? stjs_pkg::BLOCK_W'(1) : jump_dist;
  assign bs_ext    = StepW'(bs_eff);
  assign n_ext     = StepW'(count);
  assign jump_lim  = (step_issue < n_ext) ? step_issue : n_ext;
  assign jump_addr = jump_lim - StepW'(1);
  assign rd_addr   = cmd.scan ? scan_issue[AW-1:0] : jump_addr[AW-1:0];

  assign is_full   = (count == CntW'(TABLE_DEPTH));
  assign is_order  = (count != '0) && (item.value < last_word);
  assign do_write  = cmd.accept && (item.op == stjs_pkg::OP_APPEND) && !is_full && !is_order;

  assign ge_target = (rd_data >= target);
  assign eq_target = (rd_data == target);
  // saturate at the top of the count field
  assign cmp_inc   = (res_cmp == '1) ? res_cmp : res_cmp + CW'(1);

  always_comb begin
    stat            = '0;
    stat.count_zero = (count == '0);
    stat.jump_hit   = rd_vld && ge_target;
    stat.jump_miss  = rd_vld && !ge_target && (cmp_pos >= n_ext);
    stat.scan_hit   = rd_vld && eq_target;
    stat.scan_end   = rd_vld && !eq_target && ((cmp_pos + StepW'(1)) >= scan_stop);
  end

  // table memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[count[AW-1:0]] <= item.value;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      jump_dist <= stjs_pkg::BLOCK_RESET;
      rd_vld    <= 1'b0;
    end else begin
      if (cfg_we) begin
        jump_dist <= cfg_data;
      end
      if (cmd.accept) begin
        rd_vld <= 1'b0;
        if (item.op == stjs_pkg::OP_CLEAR) begin
          count <= '0;
        end else if (do_write) begin
          count <= count + CntW'(1);
        end
      end else if (cmd.jump) begin
        rd_vld <= !stat.jump_hit;
      end else if (cmd.scan) begin
        rd_vld <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_found  <= 1'b0;
      res_idx    <= '0;
      res_cmp    <= '0;
      target     <= item.value;
      step_issue <= bs_ext;
      unique case (item.op)
        stjs_pkg::OP_APPEND: begin
          priority if (is_full) begin
            res_status <= stjs_pkg::ST_FULL;
          end else if (is_order) begin
            res_status <= stjs_pkg::ST_ORDER;
          end else begin
            res_status <= stjs_pkg::ST_OK;
          end
        end
        stjs_pkg::OP_SEARCH: begin
          res_status <= (count == '0) ? stjs_pkg::ST_EMPTY : stjs_pkg::ST_OK;
        end
        default: res_status <= stjs_pkg::ST_OK;
      endcase
    end else if (cmd.jump) begin
      // reads run one block ahead of the compare
      step_issue <= step_issue + bs_ext;
      cmp_pos    <= step_issue;
      if (rd_vld) begin
        res_cmp <= cmp_inc;
      end
      if (stat.jump_hit) begin
        scan_issue <= cmp_pos - bs_ext;
        scan_stop  <= (cmp_pos < n_ext) ? cmp_pos : n_ext;
      end
    end else if (cmd.scan) begin
      scan_issue <= scan_issue + StepW'(1);
      cmp_pos    <= scan_issue;
      if (rd_vld) begin
        res_cmp <= cmp_inc;
      end
      if (stat.scan_hit) begin
        res_found <= 1'b1;
        res_idx   <= cmp_pos[IW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      last_word <= item.value;
    end
    if (cmd.load_out) begin
      result.status        <= res_status;
      result.found         <= res_found;
      result.index         <= res_idx;
      result.compare_count <= res_cmp;
    end
  end

endmodule

/* tb/search_result_checker.sv */
// result checker for the sorted table jump search block: watches the item, result
// and block size channels, predicts every result and compares it field by field
// depends on stjs_pkg
module search_result_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  input  logic                         item_stall,
  input  stjs_pkg::item_t              item,
  input  logic                         result_valid,
  input  logic                         result_stall,
  input  stjs_pkg::result_t            result,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [stjs_pkg::BLOCK_W-1:0] cfg_data,
  output int                           mismatch_count,
  output int                           pending,
  output int                           hit_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [stjs_pkg::VALUE_W-1:0] entries [stjs_pkg::TABLE_DEPTH];
  int                                  n_entries;
  logic [stjs_pkg::BLOCK_W-1:0]        jump_len;
  stjs_pkg::result_t                   answer_q [$];

  // applies one item to the local copy of the table and returns its answer
  function automatic stjs_pkg::result_t predict_lookup(stjs_pkg::item_t it);
    stjs_pkg::result_t res;
    int      bs, lo, hi, last, cmp;
    bit      hit, done;
    res = '0;
    case (it.op)
      stjs_pkg::OP_CLEAR: begin
        n_entries = 0;
      end
      stjs_pkg::OP_APPEND: begin
        if (n_entries >= stjs_pkg::TABLE_DEPTH) begin
          res.status = stjs_pkg::ST_FULL;
        end else if (n_entries > 0 &&
                     $signed(it.value) < $signed(entries[n_entries-1])) begin
          res.status = stjs_pkg::ST_ORDER;
        end else begin
          entries[n_entries] = it.value;
          n_entries++;
        end
      end
      stjs_pkg::OP_SEARCH: begin
        if (n_entries == 0) begin
          res.status = stjs_pkg::ST_EMPTY;
        end else begin
          bs   = (jump_len == 0) ? 1 : int'(jump_len);
          lo   = 0;
          hi   = bs;
          cmp  = 0;
          hit  = 1'b0;
          done = 1'b0;
          // jump over whole blocks while their last word is below the target
          while (!done) begin
            last = (hi < n_entries) ? hi : n_entries;
            cmp++;
            if ($signed(entries[last-1]) >= $signed(it.value)) begin
              hit  = 1'b1;
              done = 1'b1;
            end else begin
              lo = hi;
              hi += bs;
              if (lo >= n_entries) done = 1'b1;
            end
          end
          if (hit) begin
            last = (hi < n_entries) ? hi : n_entries;
            for (int i = lo; i < last; i++) begin
              cmp++;
              if (entries[i] == it.value) begin
                res.found = 1'b1;
                res.index = stjs_pkg::INDEX_W'(i);
                break;
              end
            end
          end
          res.compare_count = (cmp > 4095) ? '1 : stjs_pkg::COUNT_W'(cmp);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    stjs_pkg::result_t want;
    if (rst) begin
      n_entries      = 0;
      jump_len       = stjs_pkg::BLOCK_RESET;
      answer_q.delete();
      mismatch_count = 0;
      hit_count      = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (answer_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result with nothing outstanding:", $realtime,
                     " status %0d found %0d index %0d count %0d",
                     result.status, result.found, result.index,
                     result.compare_count);
        end else begin
          want = answer_q.pop_front();
          if (want.found) hit_count++;
          if (result.status !== want.status || result.found !== want.found ||
              result.index !== want.index ||
              result.compare_count !== want.compare_count) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: mismatch, expected status %0d found %0d index %0d count %0d,",
                       $realtime, want.status, want.found, want.index,
                       want.compare_count,
                       " got status %0d found %0d index %0d count %0d",
                       result.status, result.found, result.index,
                       result.compare_count);
          end
        end
      end
      if (cfg_valid && cfg_ready) jump_len = cfg_data;
      if (item_valid && !item_stall) answer_q.insert(answer_q.size(), predict_lookup(item));
    end
    pending = answer_q.size();
  end

endmodule

/* tb/testbench.sv */
// top of the sorted table jump search testbench: clock, reset, stimulus and verdict
// depends on stjs_pkg, sorted_table_jump_search_core and search_result_checker
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam longint     MIN_WORD    = -64'sd2147483648;
  localparam longint     MAX_WORD    = 64'sd2147483647;
  localparam int         QUIET_LIMIT = 10000;
  localparam int         FILL_LEN    = 90;

  logic                         clk          = 1'b0;
  logic                         rst          = 1'b1;
  logic                         item_valid   = 1'b0;
  logic                         item_stall;
  stjs_pkg::item_t              item         = '0;
  logic                         result_valid;
  logic                         result_stall = 1'b0;
  stjs_pkg::result_t            result;
  logic                         cfg_valid    = 1'b0;
  logic                         cfg_ready;
  logic [stjs_pkg::BLOCK_W-1:0] cfg_data     = '0;

  int     mismatch_count, pending, hit_count;
  bit     idle_on = 1'b1;
  int     stall_left = 0;
  int     quiet_cycles = 0;
  int     n_items = 0, n_searches = 0, n_settings = 0;
  longint table_vals [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sorted_table_jump_search_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  search_result_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .item           (item),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .result         (result),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending        (pending),
    .hit_count      (hit_count)
  );

  // receiver holds off results in random bursts
  always @(negedge clk) begin
    if (rst || !idle_on) begin
      stall_left   = 0;
      result_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left   = $urandom_range(1, 16) - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // ends the run when no transaction of any kind completes for too long
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout after %0d quiet cycles", quiet_cycles);
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // valid stays high from one transaction to the next unless a gap is inserted
  task automatic send_item(input logic [1:0] op, input longint v);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{op: op, value: v[stjs_pkg::VALUE_W-1:0]};
    n_items++;
    if (op == stjs_pkg::OP_SEARCH) n_searches++;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic write_jump_dist(input logic [stjs_pkg::BLOCK_W-1:0] bs);
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= bs;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  function automatic longint clamp_word(input longint v);
    if (v > MAX_WORD) return MAX_WORD;
    if (v < MIN_WORD) return MIN_WORD;
    return v;
  endfunction

  // mostly stored words, then near misses, out-of-range and arbitrary targets
  function automatic longint pick_target();
    longint lowest, highest;
    if (table_vals.size() == 0) return longint'($signed($urandom()));
    lowest  = table_vals[0];
    highest = table_vals[table_vals.size()-1];
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return table_vals[$urandom_range(0, table_vals.size()-1)];
      5: return clamp_word(table_vals[$urandom_range(0, table_vals.size()-1)] + 1);
      6: return clamp_word(table_vals[$urandom_range(0, table_vals.size()-1)] - 1);
      7: return clamp_word(lowest - 1 - $urandom_range(0, 1000));
      8: return clamp_word(highest + 1 + $urandom_range(0, 1000));
      default: return longint'($signed($urandom()));
    endcase
  endfunction

  // clear, build an ascending table with some noise mixed in, then search it
  task automatic run_session(input int max_len, input int n_lookups);
    longint cur, last;
    int     len;
    table_vals.delete();
    send_item(stjs_pkg::OP_CLEAR, $urandom());
    len = $urandom_range(1, max_len);
    cur = longint'($signed($urandom()));
    if ($urandom_range(0, 3) == 0) cur = MIN_WORD + $urandom_range(0, 100);
    for (int k = 0; k < len; k++) begin
      case ($urandom_range(0, 15))
        0: begin
          if (table_vals.size() > 0 && table_vals[table_vals.size()-1] > MIN_WORD) begin
            last = table_vals[table_vals.size()-1];
            send_item(stjs_pkg::OP_APPEND, clamp_word(last - 1 - $urandom_range(0, 100)));
          end else begin
            send_item(OP_UNUSED, $urandom());
          end
        end
        1: send_item(OP_UNUSED, $urandom());
        2: send_item(stjs_pkg::OP_SEARCH, pick_target());
        default: begin
          send_item(stjs_pkg::OP_APPEND, cur);
          table_vals.insert(table_vals.size(), cur);
          // repeats and dense runs are common, wide steps less so
          if ($urandom_range(0, 3) != 0)
            cur = clamp_word(cur + (($urandom_range(0, 4) == 0) ? 0 :
                                    $urandom_range(1, 1000)));
          else
            cur = clamp_word(cur + $urandom_range(0, 1 << 24));
        end
      endcase
    end
    for (int k = 0; k < n_lookups; k++) send_item(stjs_pkg::OP_SEARCH, pick_target());
  endtask

  task automatic fill_table(input int len);
    longint cur;
    table_vals.delete();
    send_item(stjs_pkg::OP_CLEAR, 0);
    cur = MIN_WORD;
    for (int k = 0; k < len; k++) begin
      send_item(stjs_pkg::OP_APPEND, cur);
      table_vals.insert(table_vals.size(), cur);
      cur = clamp_word(cur + $urandom_range(0, 7000000));
    end
  endtask

  initial begin
    logic [stjs_pkg::BLOCK_W-1:0] bs_list [9];
    bs_list = '{11'd0, 11'd1, 11'd2, 11'd3, 11'd2047, 11'd1024, 11'd7, 11'd5, 11'd0};
    bs_list[8] = stjs_pkg::BLOCK_W'($urandom_range(4, 60));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed checks with the block size left at its reset value
    send_item(stjs_pkg::OP_SEARCH, 0);
    send_item(OP_UNUSED, 32'h1234);
    send_item(stjs_pkg::OP_APPEND, MIN_WORD);
    send_item(stjs_pkg::OP_APPEND, -5);
    send_item(stjs_pkg::OP_APPEND, -5);
    send_item(stjs_pkg::OP_APPEND, 0);
    send_item(stjs_pkg::OP_APPEND, 7);
    send_item(stjs_pkg::OP_APPEND, 6);
    send_item(stjs_pkg::OP_APPEND, MAX_WORD);
    send_item(stjs_pkg::OP_SEARCH, MIN_WORD);
    send_item(stjs_pkg::OP_SEARCH, -5);
    send_item(stjs_pkg::OP_SEARCH, 7);
    send_item(stjs_pkg::OP_SEARCH, MAX_WORD);
    send_item(stjs_pkg::OP_SEARCH, 3);
    send_item(stjs_pkg::OP_SEARCH, MIN_WORD + 1);
    send_item(OP_UNUSED, -1);
    send_item(stjs_pkg::OP_CLEAR, -1);
    send_item(stjs_pkg::OP_SEARCH, 5);
    send_item(stjs_pkg::OP_APPEND, 1);
    send_item(stjs_pkg::OP_APPEND, 2);
    send_item(stjs_pkg::OP_SEARCH, 100);
    send_item(stjs_pkg::OP_SEARCH, -100);
    send_item(stjs_pkg::OP_SEARCH, 2);
    send_item(stjs_pkg::OP_CLEAR, 0);

    foreach (bs_list[s]) begin
      write_jump_dist(bs_list[s]);
      run_session(30, 8);
      if (bs_list[s] == 11'd1 || bs_list[s] == 11'd2047) run_session(100, 6);
    end

    // last part without idling: a larger table at several block sizes
    idle_on = 1'b0;
    write_jump_dist(stjs_pkg::BLOCK_RESET);
    fill_table(FILL_LEN);
    send_item(stjs_pkg::OP_SEARCH, table_vals[FILL_LEN-1]);
    send_item(stjs_pkg::OP_SEARCH, table_vals[0]);
    send_item(stjs_pkg::OP_SEARCH, table_vals[FILL_LEN/2]);
    send_item(stjs_pkg::OP_SEARCH, clamp_word(table_vals[10] + 1));
    send_item(stjs_pkg::OP_SEARCH, MAX_WORD);
    for (int k = 0; k < 6; k++) send_item(stjs_pkg::OP_SEARCH, pick_target());
    write_jump_dist(11'd1);
    send_item(stjs_pkg::OP_SEARCH, table_vals[FILL_LEN-1]);
    send_item(stjs_pkg::OP_SEARCH, MAX_WORD);
    write_jump_dist(11'd2047);
    send_item(stjs_pkg::OP_SEARCH, table_vals[FILL_LEN-1]);
    send_item(stjs_pkg::OP_SEARCH, table_vals[0]);
    send_item(stjs_pkg::OP_SEARCH, table_vals[60]);
    write_jump_dist(11'd9);
    send_item(stjs_pkg::OP_SEARCH, table_vals[FILL_LEN-1]);
    send_item(stjs_pkg::OP_SEARCH, pick_target());

    @(negedge clk);
    item_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);

    $display("sent %0d items, %0d searches of which %0d found their target,",
             n_items, n_searches, hit_count,
             " over %0d block size settings", n_settings + 1);
    $display("covered empty and partial tables, rejected appends and the unused op code");
    if (mismatch_count == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/stjs_pkg.sv
sv/stjs_ctrl.sv
sv/stjs_datapath.sv
sv/sorted_table_jump_search_core.sv
tb/search_result_checker.sv
tb/testbench.sv
